// ===== rtl/core/spr_pkg.sv =====
`default_nettype none

package spr_pkg;

   // Request operation codes
   localparam logic [2:0] OP_PRESET   = 3'd0;
   localparam logic [2:0] OP_TARGET   = 3'd1;
   localparam logic [2:0] OP_RETARGET = 3'd2;
   localparam logic [2:0] OP_NUDGE    = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;

   // Register indexes on the csr channel
   localparam logic [1:0] CSR_TICK_MODE  = 2'd0;
   localparam logic [1:0] CSR_STEP_LIMIT = 2'd1;
   localparam logic [1:0] CSR_DEADBAND   = 2'd2;

   // Tick modes for a zero-step tick
   localparam logic [1:0] MODE_PLAIN    = 2'd0;
   localparam logic [1:0] MODE_CAPPED   = 2'd1;
   localparam logic [1:0] MODE_DEADBAND = 2'd2;

   // Field widths
   localparam int unsigned PULSE_W  = 13;
   localparam int unsigned STEP_W   = 14;
   localparam int unsigned RATE_W   = 17;
   localparam int unsigned RELOAD_W = 16;

   // Pulse and step limits
   localparam logic [PULSE_W-1:0]        PULSE_MAX = 13'd7111;
   localparam logic signed [STEP_W-1:0]  STEP_MAX  = 14'sd8191;
   localparam logic signed [STEP_W-1:0]  STEP_MIN  = -14'sd8192;

   // Register reset values
   localparam logic [PULSE_W-1:0] STEP_LIMIT_RST = 13'd7111;

   // Reload scaling: p*9216/1000 = (p*1152)/125, with 1/125 as ceil(2^30/125)
   localparam int unsigned          SCALE_W     = 24;
   localparam logic [SCALE_W-1:0]   RECIP_125   = 24'd8589935;
   localparam int unsigned          RECIP_SHIFT = 30;

endpackage

`default_nettype wire

// ===== rtl/core/servo_pulse_ramp_controller.sv =====
`default_nettype none
// Servo pulse ramp controller (slew-rate limiter).
// Requests arrive on req_: req_tuser carries the operation (preset, target
// with rate, retarget, nudge, tick) and req_tdata the pulse value, rate and
// nudge amount. Every request yields exactly one result on rsp_: timer
// reload word, current pulse width and the reached flag.
// Tick mode, step limit and deadband are written over the csr_ channel,
// which is always ready; write them only while no request is in flight.
// A request accepted at one edge shows its result at rsp_ in the next cycle.
// One request per cycle while rsp_ does not stall; the state update, the
// rate multiply and the reload multiply all sit in one stage in front of
// the result register.
// A waiting result holds while rsp_tready is low, and req_tready drops;
// it stays high while the result register is empty or being drained, so a
// new request enters in the same cycle the previous result is taken.
// Reset (synchronous, active high) clears current pulse, target pulse and
// ramp step, empties the result register and restores tick mode 0,
// step limit 7111 and deadband 0.
module servo_pulse_ramp_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: pulse_value[12:0], rate_q16[29:13], nudge_amount[43:30], zero pad
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   // req_tuser: operation[2:0]
   input  wire logic [2:0]  req_tuser,
   // rsp_tdata: timer_reload[15:0], pulse_now[28:16], reached[29], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_data
);
   import spr_pkg::*;

   // State and registers
   logic [PULSE_W-1:0]        cur_ff, cur_in;
   logic [PULSE_W-1:0]        tgt_ff, tgt_in;
   logic signed [STEP_W-1:0]  step_ff, step_in;
   logic [1:0]                tick_mode_ff;
   logic [PULSE_W-1:0]        step_limit_ff;
   logic [PULSE_W-1:0]        deadband_ff;

   // Result register
   logic                      rsp_valid_ff;
   logic [RELOAD_W-1:0]       reload_ff;
   logic [PULSE_W-1:0]        pulse_ff;
   logic                      reached_ff, reached_in;
   logic [RELOAD_W-1:0]       reload_in;

   // Request fields
   logic [2:0]                op;
   logic [PULSE_W-1:0]        pv;
   logic [RATE_W-1:0]         rate;
   logic signed [STEP_W-1:0]  nudge;
   logic                      req_fire;

   // Target-with-rate step
   logic signed [STEP_W-1:0]  diff_new;
   logic [PULSE_W-1:0]        mag_new;
   logic [PULSE_W+RATE_W-1:0] rate_prod;
   logic [STEP_W-1:0]         rate_q;
   logic signed [STEP_W-1:0]  rate_step;

   // Retarget flip, nudge and tick arithmetic
   logic signed [STEP_W-1:0]  flip_step;
   logic signed [15:0]        nudged;
   logic signed [STEP_W-1:0]  jdiff;
   logic [PULSE_W-1:0]        jmag;
   logic [PULSE_W-1:0]        jump_tgt;
   logic signed [15:0]        ramp_next;
   logic signed [15:0]        tgt_s;

   assign op    = req_tuser;
   assign pv    = req_tdata[12:0];
   assign rate  = req_tdata[29:13];
   assign nudge = $signed(req_tdata[43:30]);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Step from rate: truncate toward zero, saturate to the step range
   assign diff_new  = $signed({1'b0, pv}) - $signed({1'b0, cur_ff});
   assign mag_new   = diff_new[STEP_W-1] ? PULSE_W'(-diff_new) : PULSE_W'(diff_new);
   assign rate_prod = (PULSE_W+RATE_W)'(mag_new) * (PULSE_W+RATE_W)'(rate);
   assign rate_q    = rate_prod[16 +: STEP_W];

   always_comb begin
      if (diff_new[STEP_W-1]) begin
         if (rate_q > STEP_W'(8192)) begin
            rate_step = STEP_MIN;
         end else begin
            rate_step = STEP_W'(0) - rate_q;
         end
      end else begin
         if (rate_q > STEP_W'(8191)) begin
            rate_step = STEP_MAX;
         end else begin
            rate_step = rate_q;
         end
      end
   end

   // Point the step toward the new target
   always_comb begin
      flip_step = step_ff;
      if (pv < cur_ff) begin
         if (step_ff > 0) begin
            flip_step = -step_ff;
         end
      end else if (step_ff < 0) begin
         flip_step = (step_ff == STEP_MIN) ? STEP_MAX : -step_ff;
      end
   end

   assign nudged = $signed({3'b0, tgt_ff}) + 16'(nudge);

   // Zero-step tick: optional deadband and cap on the jump
   assign jdiff = $signed({1'b0, tgt_ff}) - $signed({1'b0, cur_ff});
   assign jmag  = jdiff[STEP_W-1] ? PULSE_W'(-jdiff) : PULSE_W'(jdiff);

   always_comb begin
      jump_tgt = tgt_ff;
      if (tick_mode_ff != MODE_PLAIN) begin
         if (tick_mode_ff[1] && jmag < deadband_ff) begin
            jump_tgt = cur_ff;
         end else if (jmag > step_limit_ff) begin
            jump_tgt = jdiff[STEP_W-1] ? cur_ff - step_limit_ff : cur_ff + step_limit_ff;
         end
      end
   end

   assign ramp_next = $signed({3'b0, cur_ff}) + 16'(step_ff);
   assign tgt_s     = $signed({3'b0, tgt_ff});

   // Next state per operation
   always_comb begin
      cur_in     = cur_ff;
      tgt_in     = tgt_ff;
      step_in    = step_ff;
      reached_in = 1'b0;
      case (op)
         OP_PRESET: begin
            cur_in = pv;
            tgt_in = pv;
         end
         OP_TARGET: begin
            tgt_in  = pv;
            step_in = rate_step;
         end
         OP_RETARGET: begin
            tgt_in  = pv;
            step_in = flip_step;
         end
         OP_NUDGE: begin
            step_in = '0;
            if (nudged < 0) begin
               tgt_in = '0;
            end else if (nudged > $signed({3'b0, PULSE_MAX})) begin
               tgt_in = PULSE_MAX;
            end else begin
               tgt_in = PULSE_W'(nudged);
            end
         end
         OP_TICK: begin
            if (step_ff == 0) begin
               tgt_in = jump_tgt;
               cur_in = jump_tgt;
            end else if ((step_ff > 0 && ramp_next > tgt_s) ||
                         (step_ff < 0 && ramp_next < tgt_s)) begin
               cur_in     = tgt_ff;
               reached_in = 1'b1;
            end else begin
               cur_in = PULSE_W'(ramp_next);
            end
         end
         default: begin
         end
      endcase
   end

   spr_reload u_reload (
      .pulse  (cur_in),
      .reload (reload_in)
   );

   // Advance state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         tgt_ff  <= '0;
         step_ff <= '0;
      end else if (req_fire) begin
         cur_ff  <= cur_in;
         tgt_ff  <= tgt_in;
         step_ff <= step_in;
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_mode_ff  <= MODE_PLAIN;
         step_limit_ff <= STEP_LIMIT_RST;
         deadband_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TICK_MODE:  tick_mode_ff  <= csr_data[1:0];
            CSR_STEP_LIMIT: step_limit_ff <= csr_data;
            CSR_DEADBAND:   deadband_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Result valid: set on request, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         reload_ff  <= reload_in;
         pulse_ff   <= cur_in;
         reached_ff <= reached_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b0, reached_ff, pulse_ff, reload_ff};

endmodule

`default_nettype wire

// ===== rtl/core/spr_reload.sv =====
`default_nettype none

module spr_reload (
   input  wire logic [spr_pkg::PULSE_W-1:0]  pulse,
   output logic      [spr_pkg::RELOAD_W-1:0] reload
);
   import spr_pkg::*;

   logic [SCALE_W-1:0]   scaled_pulse;
   logic [2*SCALE_W-1:0] recip_prod;
   logic [RELOAD_W-1:0]  ticks;

   // Scale by 1152 with shifts: 1024 + 128
   assign scaled_pulse = (SCALE_W'(pulse) << 10) + (SCALE_W'(pulse) << 7);

   // Divide by 125 through the reciprocal
   assign recip_prod = (2*SCALE_W)'(scaled_pulse) * (2*SCALE_W)'(RECIP_125);
   assign ticks      = recip_prod[RECIP_SHIFT +: RELOAD_W];

   // Count-up timer reload, wrapping at 16 bits
   assign reload = RELOAD_W'(0) - ticks;

endmodule

`default_nettype wire

// ===== rtl/core/spr_checker.sv =====
`default_nettype none

module spr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Every accepted request shows a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted request produced no result");

   // Requests are taken whenever the result side is free
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled with result side free");

   // Zero pulse maps to a zero reload word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[28:16] == 13'd0) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("reload mismatch for zero pulse");

   // Stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind servo_pulse_ramp_controller spr_checker u_spr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/servo_pulse_ramp_controller_test.sv =====
`timescale 1ns / 100ps

module servo_pulse_ramp_controller_test;
   import spr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int NUDGE_W = 14;
   localparam int RATE_ONE = 65536;
   localparam int PRINT_LIMIT = 25;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 210;

   // Operation codes the block leaves undefined
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;
   // Tick mode code outside the documented set, treated like deadband mode
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct {
      logic [2:0]                 op;
      logic [PULSE_W-1:0]         pulse;
      logic [RATE_W-1:0]          rate;
      logic signed [NUDGE_W-1:0]  nudge;
   } servo_cmd_type;

   typedef struct {
      logic [RELOAD_W-1:0] reload;
      logic [PULSE_W-1:0]  pulse;
      logic                reached;
   } servo_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   servo_cmd_type    cmd_backlog[$];
   servo_result_type pending_results[$];
   servo_cmd_type    next_cmd;
   servo_cmd_type    seen_cmd;
   servo_result_type got_result;
   servo_result_type want_result;

   // Predictor copy of the block's state and registers
   int cur_pulse = 0;
   int tgt_pulse = 0;
   int ramp_step = 0;
   int mode_reg = 0;
   int limit_reg = 7111;
   int band_reg = 0;

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  req_taken = 1'b0;
   int  cycle_count = 0;
   int  error_count = 0;
   int  req_count = 0;
   int  rsp_count = 0;
   int  reached_count = 0;
   int  csr_count = 0;

   servo_pulse_ramp_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Clip a step to the 14-bit signed range
   function automatic int clip_step(longint v);
      if (v > longint'(STEP_MAX)) return int'(STEP_MAX);
      if (v < longint'(STEP_MIN)) return int'(STEP_MIN);
      return int'(v);
   endfunction

   // Apply one request to the predicted state and return its result
   function automatic servo_result_type advance_servo(servo_cmd_type cmd);
      servo_result_type r;
      longint prod;
      longint scaled;
      int next;
      int diff;
      int mag;
      r.reached = 1'b0;
      case (cmd.op)
         OP_PRESET: begin
            cur_pulse = int'(cmd.pulse);
            tgt_pulse = int'(cmd.pulse);
         end
         OP_TARGET: begin
            tgt_pulse = int'(cmd.pulse);
            prod = longint'(tgt_pulse - cur_pulse) * longint'(cmd.rate);
            // signed division truncates toward zero
            ramp_step = clip_step(prod / RATE_ONE);
         end
         OP_RETARGET: begin
            tgt_pulse = int'(cmd.pulse);
            if (tgt_pulse < cur_pulse) begin
               if (ramp_step > 0) ramp_step = -ramp_step;
            end else if (ramp_step < 0) begin
               ramp_step = clip_step(-longint'(ramp_step));
            end
         end
         OP_NUDGE: begin
            next = tgt_pulse + int'(cmd.nudge);
            ramp_step = 0;
            if (next < 0) next = 0;
            if (next > int'(PULSE_MAX)) next = int'(PULSE_MAX);
            tgt_pulse = next;
         end
         OP_TICK: begin
            if (ramp_step == 0) begin
               // jump tick: cap and deadband move the target itself
               if (mode_reg != int'(MODE_PLAIN)) begin
                  diff = tgt_pulse - cur_pulse;
                  mag = (diff < 0) ? -diff : diff;
                  if (mode_reg >= int'(MODE_DEADBAND) && mag < band_reg)
                     tgt_pulse = cur_pulse;
                  else if (mag > limit_reg)
                     tgt_pulse = (diff > 0) ? cur_pulse + limit_reg : cur_pulse - limit_reg;
               end
               cur_pulse = tgt_pulse;
            end else begin
               // ramp tick: clamp at the target when passing it
               next = cur_pulse + ramp_step;
               if ((ramp_step > 0 && next > tgt_pulse) ||
                   (ramp_step < 0 && next < tgt_pulse)) begin
                  next = tgt_pulse;
                  r.reached = 1'b1;
               end
               cur_pulse = next;
            end
         end
         default: ;
      endcase
      scaled = (longint'(cur_pulse) * 9216) / 1000;
      r.reload = 16'(RATE_ONE - (scaled & 65535));
      r.pulse = 13'(cur_pulse);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic push_cmd(logic [2:0] op, int pulse, int rate, int nudge);
      servo_cmd_type cmd;
      cmd.op = op;
      cmd.pulse = pulse[12:0];
      cmd.rate = rate[16:0];
      cmd.nudge = nudge[13:0];
      cmd_backlog.push_back(cmd);
   endtask

   function automatic int pick_pulse();
      case ($urandom_range(7))
         0: return 0;
         1: return int'(PULSE_MAX);
         default: return int'($urandom_range(PULSE_MAX));
      endcase
   endfunction

   function automatic int pick_rate();
      case ($urandom_range(9))
         0: return 0;
         1: return RATE_ONE;
         2: return int'($urandom_range(64, 1));
         3, 4: return int'($urandom_range(RATE_ONE));
         default: return int'($urandom_range(16384));
      endcase
   endfunction

   function automatic int pick_nudge();
      int v;
      case ($urandom_range(7))
         0: v = int'(PULSE_MAX);
         1: v = -int'(PULSE_MAX);
         2: v = int'($urandom_range(40)) - 20;
         default: v = int'($urandom_range(14222)) - int'(PULSE_MAX);
      endcase
      return v;
   endfunction

   // Queue command bursts: a lead command followed by a run of ticks
   task automatic queue_random_mix(int n);
      int made;
      int roll;
      int ticks;
      logic [2:0] lead;
      made = 0;
      while (made < n) begin
         roll = $urandom_range(99);
         ticks = $urandom_range(6);
         if (roll < 10) begin
            lead = OP_PRESET;
            ticks = ticks / 3;
         end else if (roll < 45) lead = OP_TARGET;
         else if (roll < 60) lead = OP_RETARGET;
         else if (roll < 75) lead = OP_NUDGE;
         else if (roll < 80) begin
            lead = 3'($urandom_range(OP_SPARE_C, OP_SPARE_A));
            ticks = 0;
         end else begin
            lead = OP_TICK;
            ticks = 0;
         end
         push_cmd(lead, pick_pulse(), pick_rate(), pick_nudge());
         repeat (ticks) push_cmd(OP_TICK, pick_pulse(), pick_rate(), pick_nudge());
         made += 1 + ticks;
      end
   endtask

   // Wait until every request is sent and every result has come back
   task automatic wait_idle();
      @(posedge clock);
      #1;
      while (cmd_backlog.size() != 0 || req_tvalid || pending_results.size() != 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [12:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drive requests and receiver stalls at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd = cmd_backlog.pop_front();
               req_tuser <= next_cmd.op;
               req_tdata <= {4'b0, next_cmd.nudge, next_cmd.rate, next_cmd.pulse};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Check results, predict accepted requests and track register writes
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got_result.reload = rsp_tdata[15:0];
            got_result.pulse = rsp_tdata[28:16];
            got_result.reached = rsp_tdata[29];
            if (pending_results.size() == 0) begin
               report_mismatch("result with no request pending", int'(got_result.pulse), -1);
            end else begin
               want_result = pending_results.pop_front();
               if (got_result.reload !== want_result.reload)
                  report_mismatch("timer_reload", int'(got_result.reload),
                                  int'(want_result.reload));
               if (got_result.pulse !== want_result.pulse)
                  report_mismatch("pulse_now", int'(got_result.pulse), int'(want_result.pulse));
               if (got_result.reached !== want_result.reached)
                  report_mismatch("reached", int'(got_result.reached),
                                  int'(want_result.reached));
            end
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            seen_cmd.op = req_tuser;
            seen_cmd.pulse = req_tdata[12:0];
            seen_cmd.rate = req_tdata[29:13];
            seen_cmd.nudge = req_tdata[43:30];
            want_result = advance_servo(seen_cmd);
            if (want_result.reached) reached_count++;
            pending_results.push_back(want_result);
            req_count++;
         end
         if (csr_valid && csr_ready) begin
            csr_count++;
            case (csr_index)
               CSR_TICK_MODE:  mode_reg = int'(csr_data[1:0]);
               CSR_STEP_LIMIT: limit_reg = int'(csr_data);
               CSR_DEADBAND:   band_reg = int'(csr_data);
               default: ;
            endcase
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [1:0]  mode_plan[NUM_PHASES];
      logic [12:0] limit_plan[NUM_PHASES];
      logic [12:0] band_plan[NUM_PHASES];
      int          idle_plan[4][2];

      mode_plan  = '{MODE_PLAIN, MODE_CAPPED, MODE_CAPPED, MODE_DEADBAND,
                     MODE_DEADBAND, MODE_SPARE, MODE_CAPPED, MODE_DEADBAND};
      limit_plan = '{13'd7111, 13'd0, 13'd300, 13'd7111, 13'd400, 13'd50, 13'd7111, 13'd0};
      band_plan  = '{13'd0, 13'd0, 13'd0, 13'd7111, 13'd150, 13'd2000, 13'd7111, 13'd0};
      idle_plan  = '{'{0, 0}, '{55, 0}, '{0, 55}, '{38, 38}};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every operation, clamp and truncation cases
      send_idle_pct = 38;
      rsp_stall_pct = 38;
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_PRESET, int'(PULSE_MAX), RATE_ONE, int'(PULSE_MAX));
      push_cmd(OP_NUDGE, 0, 0, int'(PULSE_MAX));
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_NUDGE, 0, 0, -int'(PULSE_MAX));
      push_cmd(OP_NUDGE, 0, 0, -int'(PULSE_MAX));
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_TARGET, int'(PULSE_MAX), 40000, 0);
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_RETARGET, 100, 0, 0);
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_RETARGET, 5000, 0, 0);
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_PRESET, 1000, 0, 0);
      push_cmd(OP_TARGET, 0, 1, 0);
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_PRESET, 1000, 0, 0);
      push_cmd(OP_TARGET, 0, 100, 0);
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_TARGET, int'(PULSE_MAX), RATE_ONE, 0);
      push_cmd(OP_TICK, 0, 0, 0);
      push_cmd(OP_SPARE_A, int'(PULSE_MAX), RATE_ONE, -1);
      push_cmd(OP_SPARE_B, 0, 0, 0);
      push_cmd(OP_SPARE_C, 4096, RATE_ONE, -8192);

      // Random phases, each with its own register setting; idle patterns rotate
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         write_csr(CSR_TICK_MODE, 13'(mode_plan[ph]));
         write_csr(CSR_STEP_LIMIT, limit_plan[ph]);
         write_csr(CSR_DEADBAND, band_plan[ph]);
         send_idle_pct = idle_plan[ph % 4][0];
         rsp_stall_pct = idle_plan[ph % 4][1];
         queue_random_mix(PHASE_ITEMS / 2);
         // hold the sender until everything in flight has drained
         if (ph % 2 == 1) wait_idle();
         queue_random_mix(PHASE_ITEMS / 2);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("covered %0d requests and %0d results (%0d clamped ramps)",
               req_count, rsp_count, reached_count);
      $display("across %0d register settings with %0d register writes",
               NUM_PHASES, csr_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results outstanding", error_count,
                  pending_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
